[src/salc_pkg.sv]
package salc_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_SETS    = 64;
  localparam int DEF_MAX_WAYS    = 8;
  localparam int DEF_LINE_OFS_W  = 6;

  // Fixed field widths
  localparam int ADDR_W     = 32;
  localparam int STAMP_W    = 32;
  localparam int WAY_OUT_W  = 3;
  localparam int SET_OUT_W  = 6;
  localparam int SB_W       = 3;
  localparam int WAYS_CFG_W = 4;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 4;

  localparam logic [CFG_INDEX_W-1:0] CFG_SET_BITS  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WAYS_USED = 2'd1;

  localparam logic [SB_W-1:0]       RST_SET_BITS  = 3'd6;
  localparam logic [WAYS_CFG_W-1:0] RST_WAYS_USED = 4'd8;

endpackage

[src/set_assoc_lru_cache_tags.sv]
// Channel    Ports                                      Handshake
// ---------  -----------------------------------------  ---------------------------
// request    address, is_write                          start & !busy
// result     hit, way, set_index, writeback             done, one cycle, no stall
// config     cfg_index, cfg_data                        cfg_valid & cfg_ready
//
// After rst the tag memory is swept clear, one set per cycle, with busy high
// throughout. An access is then accepted with the set row read, scanned way by
// way through the shared tag and stamp comparators, and finished with the
// row written back. The scan covers the way count in use (ways_used clamped to
// 1..MAX_WAYS) on a miss, or the hit way + 1 on a hit, stopping at the first match.
// done pulses the cycle after the write-back, when busy is already low.
// cfg_ready is always high; the receiver of results cannot stall.
module set_assoc_lru_cache_tags #(
  parameter int MAX_SETS    = salc_pkg::DEF_MAX_SETS,
  parameter int MAX_WAYS    = salc_pkg::DEF_MAX_WAYS,
  parameter int LINE_OFS_W  = salc_pkg::DEF_LINE_OFS_W
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [salc_pkg::ADDR_W-1:0]        address,
  input  logic                               is_write,
  output logic                               done,
  output logic                               hit,
  output logic [salc_pkg::WAY_OUT_W-1:0]     way,
  output logic [salc_pkg::SET_OUT_W-1:0]     set_index,
  output logic                               writeback,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [salc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [salc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int SET_BITS_MAX = $clog2(MAX_SETS + 1) - 1;
  localparam int SET_IDX_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W        = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int TAG_W        = salc_pkg::ADDR_W - LINE_OFS_W;

  typedef struct packed {
    logic                          valid;
    logic                          dirty;
    logic [TAG_W-1:0]              tag;
    logic [salc_pkg::STAMP_W-1:0]  stamp;
  } line_t;

  typedef line_t [MAX_WAYS-1:0] row_t;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_t;

  state_t state, state_next;

  // one row per set, all ways side by side
  row_t mem [MAX_SETS];

  logic [salc_pkg::SB_W-1:0]        set_bits;
  logic [salc_pkg::WAYS_CFG_W-1:0]  ways_used;
  logic [salc_pkg::STAMP_W-1:0]     access_clock;
  logic [SET_IDX_W-1:0]             clr_idx;

  row_t                             row_q;
  logic [SET_IDX_W-1:0]             set_q;
  logic [TAG_W-1:0]                 tag_q;
  logic                             wr_q;
  logic [salc_pkg::SET_OUT_W-1:0]   set_out_q;
  logic [WAY_W-1:0]                 scan_way;

  logic                             hit_found;
  logic [WAY_W-1:0]                 hit_way;
  logic                             hit_dirty;
  logic                             inv_found;
  logic [WAY_W-1:0]                 inv_way;
  logic [salc_pkg::STAMP_W-1:0]     min_stamp;
  logic [WAY_W-1:0]                 min_way;
  logic                             min_dirty;

  logic                             accept;
  logic [3:0]                       sb_eff;
  logic [4:0]                       shift_tag;
  logic [salc_pkg::ADDR_W-1:0]      set_full;
  logic [salc_pkg::ADDR_W-1:0]      tag_full;
  logic [4:0]                       ways5;
  logic [4:0]                       nways5;
  logic [WAY_W-1:0]                 last_way;

  line_t                            cur;
  logic                             match;
  logic                             is_last;

  logic [WAY_W-1:0]                 pick;
  line_t                            new_line;
  row_t                             new_row;

  logic                             mem_we;
  logic [SET_IDX_W-1:0]             mem_waddr;
  row_t                             mem_wdata;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // address split under the clamped set count
  always_comb begin
    sb_eff    = ({1'b0, set_bits} > 4'(SET_BITS_MAX)) ? 4'(SET_BITS_MAX) : {1'b0, set_bits};
    shift_tag = 5'(LINE_OFS_W) + {1'b0, sb_eff};
    set_full  = (address >> LINE_OFS_W) & ((32'd1 << sb_eff) - 32'd1);
    tag_full  = address >> shift_tag;
  end

  always_comb begin
    ways5 = {1'b0, ways_used};
    if (ways5 == 5'd0) begin
      nways5 = 5'd1;
    end else if (ways5 > 5'(MAX_WAYS)) begin
      nways5 = 5'(MAX_WAYS);
    end else begin
      nways5 = ways5;
    end
    last_way = WAY_W'(nways5 - 5'd1);
  end

  // shared comparators, one way per cycle
  always_comb begin
    cur     = row_q[scan_way];
    match   = cur.valid && (cur.tag == tag_q);
    is_last = (scan_way == last_way);
  end

  always_comb begin
    if (hit_found) begin
      pick = hit_way;
    end else if (inv_found) begin
      pick = inv_way;
    end else begin
      pick = min_way;
    end
    new_line.valid = 1'b1;
    new_line.dirty = hit_found ? (hit_dirty | wr_q) : wr_q;
    new_line.tag   = tag_q;
    new_line.stamp = access_clock;
    for (int w = 0; w < MAX_WAYS; w++) begin
      new_row[w] = (WAY_W'(w) == pick) ? new_line : row_q[w];
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = set_q;
    mem_wdata = new_row;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
        mem_wdata = '0;
      end
      ST_UPDATE: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_idx == SET_IDX_W'(MAX_SETS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (match || is_last) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (accept) row_q <= mem[set_full[SET_IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_idx      <= '0;
      set_bits     <= salc_pkg::RST_SET_BITS;
      ways_used    <= salc_pkg::RST_WAYS_USED;
      access_clock <= '0;
      done         <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_UPDATE);
      if (state == ST_CLEAR) clr_idx <= clr_idx + 1'b1;
      if (state == ST_UPDATE) access_clock <= access_clock + 1'b1;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          salc_pkg::CFG_SET_BITS:  set_bits  <= cfg_data[salc_pkg::SB_W-1:0];
          salc_pkg::CFG_WAYS_USED: ways_used <= cfg_data[salc_pkg::WAYS_CFG_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // request context and scan trackers
  always_ff @(posedge clk) begin
    if (accept) begin
      set_q     <= set_full[SET_IDX_W-1:0];
      tag_q     <= tag_full[TAG_W-1:0];
      wr_q      <= is_write;
      set_out_q <= set_full[salc_pkg::SET_OUT_W-1:0];
      scan_way  <= '0;
      hit_found <= 1'b0;
      inv_found <= 1'b0;
    end else if (state == ST_SCAN) begin
      scan_way <= scan_way + 1'b1;
      if (match) begin
        hit_found <= 1'b1;
        hit_way   <= scan_way;
        hit_dirty <= cur.dirty;
      end
      if (!cur.valid && !inv_found) begin
        inv_found <= 1'b1;
        inv_way   <= scan_way;
      end
      // strict less-than keeps the lowest way on equal stamps
      if (scan_way == '0 || cur.stamp < min_stamp) begin
        min_stamp <= cur.stamp;
        min_way   <= scan_way;
        min_dirty <= cur.dirty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_UPDATE) begin
      hit       <= hit_found;
      way       <= salc_pkg::WAY_OUT_W'(pick);
      set_index <= set_out_q;
      writeback <= !hit_found && !inv_found && min_dirty;
    end
  end

endmodule
